>>> hw/rtl/smx_pkg.sv
// Shared constants, types and tables for the softmax vector block.
package smx_pkg;

  localparam int unsigned MaxLen   = 64;
  localparam int unsigned AddrW    = $clog2(MaxLen);
  localparam int unsigned CountW   = $clog2(MaxLen + 1);
  localparam int unsigned SumW     = 23;
  localparam int unsigned ExpTerms = 12;

  // Request and response between the sequencer and the exponential unit
  typedef struct packed {
    logic        start;
    logic [15:0] delta;
  } smx_exp_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] value;
  } smx_exp_rsp_t;

  // Request and response between the sequencer and the divider
  typedef struct packed {
    logic            start;
    logic [32:0]     num;
    logic [SumW-1:0] den;
  } smx_div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } smx_div_rsp_t;

  function automatic logic [30:0] exp_int_q30(input logic [3:0] idx);
    logic [30:0] v;
    case (idx)
      4'd0:    v = 31'd1073741824;
      4'd1:    v = 31'd395007542;
      4'd2:    v = 31'd145315154;
      4'd3:    v = 31'd53458457;
      4'd4:    v = 31'd19666267;
      4'd5:    v = 31'd7234815;
      4'd6:    v = 31'd2661540;
      4'd7:    v = 31'd979126;
      4'd8:    v = 31'd360200;
      4'd9:    v = 31'd132510;
      4'd10:   v = 31'd48748;
      4'd11:   v = 31'd17933;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/smx_ram.sv
// Generic single-port RAM with registered read.
module smx_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hw/rtl/smx_exp.sv
// Iterative exp(-d/256) unit in Q1.16: Horner series over eight steps, then table scale.
module smx_exp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smx_pkg::smx_exp_req_t req_i,
  output smx_pkg::smx_exp_rsp_t rsp_o
);
  import smx_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  localparam logic [30:0] Q30One = 31'h4000_0000;

  logic [1:0]  state_q, state_d;
  logic [3:0]  k_q, k_d;
  logic [30:0] t_q, t_d;
  logic [30:0] prod_q, prod_d;
  logic [7:0]  frac_q, frac_d;
  logic [3:0]  ip_q, ip_d;
  logic [16:0] val_q, val_d;
  logic        done_q, done_d;
  logic [46:0] mul_full;
  logic [61:0] fin_full;
  logic [31:0] recip;
  logic [5:0]  rsh;
  logic [63:0] recip_full;
  logic [30:0] quo;

  // r has its low 8 bits zero, so r*t>>16 == frac*t>>8
  assign mul_full = {31'd0, frac_q, 8'd0} * {16'd0, t_q};
  // divide by the small constant k as a multiply by its rounded-up reciprocal
  always_comb begin
    case (k_q)
      4'd2: begin
        recip = 32'h8000_0000;
        rsh   = 6'd32;
      end
      4'd3: begin
        recip = 32'd2863311531;
        rsh   = 6'd33;
      end
      4'd4: begin
        recip = 32'h8000_0000;
        rsh   = 6'd33;
      end
      4'd5: begin
        recip = 32'd3435973837;
        rsh   = 6'd34;
      end
      4'd6: begin
        recip = 32'd2863311531;
        rsh   = 6'd34;
      end
      4'd7: begin
        recip = 32'd2454267027;
        rsh   = 6'd34;
      end
      4'd8: begin
        recip = 32'h8000_0000;
        rsh   = 6'd34;
      end
      default: begin
        recip = 32'h8000_0000;
        rsh   = 6'd31;
      end
    endcase
  end
  assign recip_full = {33'd0, prod_q} * {32'd0, recip};
  assign quo        = 31'(recip_full >> rsh);
  assign fin_full   = {31'd0, exp_int_q30(ip_q)} * {31'd0, t_q};

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    t_d     = t_q;
    prod_d  = prod_q;
    frac_d  = frac_q;
    ip_d    = ip_q;
    val_d   = val_q;
    done_d  = 1'b0;
    case (state_q)
      StIdle: begin
        if (req_i.start) begin
          frac_d = req_i.delta[7:0];
          ip_d   = req_i.delta[11:8];
          t_d    = Q30One;
          k_d    = 4'd8;
          if (req_i.delta[15:8] >= 8'(ExpTerms)) begin
            val_d  = '0;
            done_d = 1'b1;
          end else begin
            state_d = StMul;
          end
        end
      end
      StMul: begin
        prod_d  = mul_full[46:16];
        state_d = StDiv;
      end
      StDiv: begin
        t_d = Q30One - quo;
        k_d = k_q - 4'd1;
        if (k_q == 4'd1) state_d = StFin;
        else             state_d = StMul;
      end
      StFin: begin
        val_d   = 17'((fin_full + (62'd1 << 43)) >> 44);
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    t_q    <= t_d;
    prod_q <= prod_d;
    frac_q <= frac_d;
    ip_q   <= ip_d;
    val_q  <= val_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = val_q;
endmodule

>>> hw/rtl/smx_div.sv
// Restoring divider, one quotient bit per cycle, saturated 16-bit quotient.
module smx_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smx_pkg::smx_div_req_t req_i,
  output smx_pkg::smx_div_rsp_t rsp_o
);
  import smx_pkg::*;

  localparam int unsigned NumW = 33;

  logic            busy_q, busy_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [SumW-1:0] rem_q, rem_d;
  logic [SumW-1:0] den_q, den_d;
  logic            done_q, done_d;
  logic [SumW:0]   shifted;

  assign shifted = {rem_q, num_q[NumW-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        cnt_d  = 6'(NumW);
        num_d  = req_i.num;
        den_d  = req_i.den;
        quo_d  = '0;
        rem_d  = '0;
      end
    end else begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = SumW'(shifted - {1'b0, den_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[SumW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = (quo_q[NumW-1:16] != '0) ? 16'hFFFF : quo_q[15:0];
endmodule

>>> hw/rtl/softmax_vector.sv
// Top level of the softmax vector block: load, sum pass and output pass sequencer.
// Elements are taken one per transfer, one per cycle, until the one marked last;
// elements past 64 are dropped and flag length_error on every result. Then a sum
// pass runs the exponential unit once per element (the unit skips its series and
// returns zero when the integer part of the difference to the maximum is 12 or
// more), and an output pass recomputes each exponential and runs a 33-step
// restoring divider, one quotient bit per cycle, for each result. Elements are
// handled in turn, the divider starting once the exponential is done. The input
// is not ready from the last element until the final result is taken.
module softmax_vector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // epsilon_lsbs
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] element_value
  input  logic        s_axis_tlast,   // last_element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] probability
  output logic        m_axis_tlast,   // last_result
  output logic        m_axis_tuser    // length_error
);
  import smx_pkg::*;

  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StSRd   = 3'd1;
  localparam logic [2:0] StSExp  = 3'd2;
  localparam logic [2:0] StORd   = 3'd3;
  localparam logic [2:0] StOExp  = 3'd4;
  localparam logic [2:0] StODiv  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;
  localparam logic [2:0] StSWait = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [7:0]        eps_q;
  logic signed [15:0] max_q, max_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic              ovf_q, ovf_d;
  logic [15:0]       out_q, out_d;
  logic              olast_q, olast_d;
  logic              in_fire, store_en;
  logic [AddrW-1:0]  ram_addr;
  logic [15:0]       ram_rdata;
  logic [15:0]       delta;
  logic [16:0]       num_hi;
  smx_exp_req_t      exp_req;
  smx_exp_rsp_t      exp_rsp;
  smx_div_req_t      div_req;
  smx_div_rsp_t      div_rsp;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StLoad);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign store_en      = in_fire && (cnt_q < CountW'(MaxLen));
  assign ram_addr      = (state_q == StLoad) ? cnt_q[AddrW-1:0] : idx_q[AddrW-1:0];
  assign delta         = 16'(max_q - $signed(ram_rdata));
  assign num_hi        = {9'd0, eps_q} + exp_rsp.value;

  smx_ram #(.Width(16), .Depth(MaxLen)) u_store (
    .clk_i  (clk_i),
    .we_i   (store_en),
    .addr_i (ram_addr),
    .wdata_i(s_axis_tdata),
    .rdata_o(ram_rdata)
  );

  smx_exp u_exp (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(exp_req), .rsp_o(exp_rsp));
  smx_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  always_comb begin
    state_d = state_q;
    max_d   = max_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    out_d   = out_q;
    olast_d = olast_q;
    exp_req.start = 1'b0;
    exp_req.delta = delta;
    div_req.start = 1'b0;
    div_req.num   = {num_hi, 16'd0};
    div_req.den   = sum_q;
    case (state_q)
      StLoad: begin
        if (in_fire) begin
          if (store_en) begin
            cnt_d = cnt_q + CountW'(1);
            if ($signed(s_axis_tdata) > max_q) max_d = $signed(s_axis_tdata);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            idx_d = '0;
            sum_d = SumW'(eps_q);
            // an empty vector cannot occur: the first element is always stored
            state_d = StSRd;
          end
        end
      end
      StSRd: state_d = StSWait;
      StSWait: begin
        exp_req.start = 1'b1;
        state_d = StSExp;
      end
      StSExp: begin
        if (exp_rsp.done) begin
          sum_d = sum_q + SumW'(exp_rsp.value);
          if (idx_q + CountW'(1) == cnt_q) begin
            idx_d   = '0;
            state_d = StORd;
          end else begin
            idx_d   = idx_q + CountW'(1);
            state_d = StSRd;
          end
        end
      end
      StORd: state_d = StOExp;
      StOExp: begin
        // read data is valid now; start exponential once
        exp_req.start = 1'b1;
        state_d = StODiv;
      end
      StODiv: begin
        if (exp_rsp.done) div_req.start = 1'b1;
        if (div_rsp.done) begin
          out_d   = (sum_q == '0) ? 16'hFFFF : div_rsp.quot;
          olast_d = (idx_q + CountW'(1) == cnt_q);
          state_d = StOut;
        end
      end
      StOut: begin
        if (m_axis_tready) begin
          if (olast_q) begin
            max_d   = 16'sh8000;
            cnt_d   = '0;
            sum_d   = '0;
            ovf_d   = 1'b0;
            state_d = StLoad;
          end else begin
            idx_d   = idx_q + CountW'(1);
            state_d = StORd;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      eps_q   <= 8'd1;
      max_q   <= 16'sh8000;
      cnt_q   <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) eps_q <= cfg_data_i;
      max_q   <= max_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
      olast_q <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ovf_q;
endmodule
